FILE: rtl/atce_pkg.sv
//==============================================================================
// atce_pkg
// Shared types and constants of the text terminal cell engine.
//==============================================================================
`default_nettype none
package atce_pkg;

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_LBR = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_M   = 8'h6D;
  localparam logic [7:0] CH_D0  = 8'h30;
  localparam logic [7:0] CH_D9  = 8'h39;

  localparam logic [3:0] DEFAULT_COLOR = 4'd9;
  localparam int unsigned TAB_STEP = 4;

  localparam logic [0:0] REG_COLUMNS = 1'b0;
  localparam logic [0:0] REG_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    SEQ_NONE = 2'd0,
    SEQ_ESC  = 2'd1,
    SEQ_CSI  = 2'd2
  } seq_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_READ  = 3'd1,
    ST_OLD   = 3'd2,
    ST_NEWRD = 3'd3,
    ST_NEW   = 3'd4,
    ST_SGR   = 3'd5,
    ST_CLEAR = 3'd6,
    ST_DIV   = 3'd7
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/atce_cell_mem.sv
//==============================================================================
// atce_cell_mem
// Single-port cell store: character, foreground and background per cell.
//==============================================================================
`default_nettype none
module atce_cell_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [15:0]   wdata,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: rtl/ansi_text_terminal_cell_engine_top.sv
//==============================================================================
// ansi_text_terminal_cell_engine_top
// Byte-stream terminal: cell store, cursor and SGR color parser.
//==============================================================================
// After reset a clearing pass writes every cell of the store (blank, default
// colors), one cell a cycle, before the first byte is taken; configuration
// writes are accepted during it. A plain byte, a tab or a backspace reads the
// old cursor cell (the memory read is registered), emits it, reads the new
// cursor cell and emits that; a plain byte first writes itself with the
// current colors into the old cursor cell if that cell is in use, the old cell
// is not emitted when the old cursor lies outside the cells in use, and a
// backspace at cell zero does nothing. Newline and carriage return first find
// the cursor's column by a serial division by the column count, one quotient
// bit a cycle over the cell address width. An SGR final byte walks the stored
// parameters, one a cycle. Escape-sequence bytes that give no result leave the
// sequencer idle and may follow back to back.
// All cell state sits in one synchronous single-port memory that is read and
// written by a single sequencer, so no two accesses overlap. Results leave
// through an output register; tlast marks the final redraw item of a byte.
`default_nettype none
module ansi_text_terminal_cell_engine_top #(
  parameter int unsigned MAX_CELLS  = 8192,
  parameter int unsigned MAX_PARAMS = 8,
  parameter int unsigned MAX_DIGITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // ch
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cell_position[12:0], cell_char[20:13], fg_index[25:21], bg_index[30:26],
  // is_cursor[31]
  output logic [31:0]      out_tdata,
  output logic             out_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import atce_pkg::*;

  localparam int unsigned AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned PW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int unsigned CW = $clog2(MAX_PARAMS + 1);
  localparam int unsigned DW = $clog2(MAX_DIGITS + 1);

  // Registers.
  logic [7:0]  columns_r;
  logic [6:0]  rows_r;
  state_t      state_r, state_nxt;
  seq_t        seq_r, seq_nxt;
  logic [16:0] cursor_r, cursor_nxt;
  logic [16:0] target_r, target_nxt;
  logic [3:0]  cur_fg_r, cur_fg_nxt, cur_bg_r, cur_bg_nxt;
  logic [13:0] params_r [MAX_PARAMS];
  logic [CW-1:0] pcount_r, pcount_nxt;
  logic [13:0] number_r, number_nxt;
  logic [DW-1:0] dcount_r, dcount_nxt;
  logic [CW-1:0] pidx_r, pidx_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic [16:0] cells;
  logic [AW:0] clr_r, clr_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] od_r, od_nxt;
  logic        ol_r, ol_nxt;
  logic        pwe;
  logic [PW-1:0] pwaddr;

  // Column divider: shifted cursor, partial remainder and step count.
  logic [AW-1:0] dvd_r, dvd_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [4:0]    dstep_r, dstep_nxt;
  logic [8:0]    rem_sh;
  logic [16:0]   row_base;

  // Memory port.
  logic          mwe;
  logic [AW-1:0] maddr;
  logic [15:0]   mwdata, mrdata;

  atce_cell_mem #(.DEPTH(MAX_CELLS), .AW(AW)) u_mem (
    .clk(clk), .we(mwe), .addr(maddr), .wdata(mwdata), .rdata(mrdata)
  );

  // Cells in use; columns times rows is one small multiply.
  logic [7:0]  ecols;
  logic [6:0]  erows;
  logic [14:0] prod;
  always_comb begin
    ecols = (columns_r == 8'd0) ? 8'd1 : columns_r;
    erows = (rows_r == 7'd0) ? 7'd1 : rows_r;
    prod  = 15'(ecols) * 15'(erows);
    cells = (17'(prod) > 17'(MAX_CELLS)) ? 17'(MAX_CELLS) : 17'(prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 8'd80;
      rows_r    <= 7'd25;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: columns_r <= cfg_wdata;
        REG_ROWS:    rows_r    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  logic        digit_hit;
  logic [13:0] pv;
  logic        out_free;
  assign out_free = !ov_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    seq_nxt      = seq_r;
    cursor_nxt   = cursor_r;
    target_nxt   = target_r;
    cur_fg_nxt   = cur_fg_r;
    cur_bg_nxt   = cur_bg_r;
    pcount_nxt   = pcount_r;
    number_nxt   = number_r;
    dcount_nxt   = dcount_r;
    pidx_nxt     = pidx_r;
    ch_nxt       = ch_r;
    clr_nxt      = clr_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    dstep_nxt    = dstep_r;
    rem_sh       = {rem_r, dvd_r[AW-1]};
    row_base     = '0;
    ov_nxt       = ov_r && !out_tready;
    od_nxt       = od_r;
    ol_nxt       = ol_r;
    mwe          = 1'b0;
    maddr        = cursor_r[AW-1:0];
    mwdata       = {8'd0, DEFAULT_COLOR, DEFAULT_COLOR};
    pwe          = 1'b0;
    pwaddr       = pcount_r[PW-1:0];
    in_tready    = 1'b0;
    digit_hit    = (in_tdata >= CH_D0) && (in_tdata <= CH_D9);
    pv           = params_r[pidx_r[PW-1:0]];
    case (state_r)
      ST_CLEAR: begin
        mwe   = 1'b1;
        maddr = clr_r[AW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(MAX_CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ch_nxt = in_tdata;
          if (in_tdata == CH_LF || in_tdata == CH_CR) begin
            // The row start needs the cursor's column: divide first.
            dvd_nxt   = cursor_r[AW-1:0];
            rem_nxt   = '0;
            dstep_nxt = '0;
            state_nxt = ST_DIV;
          end else if (in_tdata == CH_TAB) begin
            target_nxt = cursor_r + 17'(TAB_STEP);
            state_nxt  = ST_READ;
          end else if (in_tdata == CH_BS && cursor_r != 17'd0) begin
            target_nxt = cursor_r - 17'd1;
            state_nxt  = ST_READ;
          end else if (in_tdata == CH_BS) begin
            state_nxt = ST_IDLE;
          end else if (in_tdata == CH_ESC) begin
            seq_nxt = SEQ_ESC; pcount_nxt = '0; number_nxt = '0; dcount_nxt = '0;
          end else if (seq_r == SEQ_ESC) begin
            seq_nxt = (in_tdata == CH_LBR) ? SEQ_CSI : SEQ_NONE;
            pcount_nxt = '0; number_nxt = '0; dcount_nxt = '0;
          end else if (seq_r == SEQ_CSI) begin
            if (digit_hit) begin
              if (dcount_r < DW'(MAX_DIGITS)) begin
                number_nxt = 14'(number_r * 14'd10 + 14'(in_tdata - CH_D0));
                dcount_nxt = dcount_r + 1'b1;
              end
            end else if (in_tdata == CH_SEMI || in_tdata == CH_M) begin
              if (pcount_r < CW'(MAX_PARAMS)) begin
                if (dcount_r != '0) begin
                  pwe = 1'b1;
                  pcount_nxt = pcount_r + 1'b1;
                end
                number_nxt = '0; dcount_nxt = '0;
              end
              if (in_tdata == CH_M) begin
                pidx_nxt  = '0;
                state_nxt = ST_SGR;
              end
            end else begin
              seq_nxt = SEQ_NONE; pcount_nxt = '0; number_nxt = '0; dcount_nxt = '0;
            end
          end else begin
            if (cursor_r < cells) begin
              mwe    = 1'b1;
              mwdata = {in_tdata, cur_fg_r, cur_bg_r};
            end
            target_nxt = cursor_r + 17'd1;
            state_nxt  = ST_READ;
          end
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a cycle; only the remainder
        // (the cursor's column) is kept.
        if (rem_sh >= {1'b0, ecols}) rem_sh = rem_sh - {1'b0, ecols};
        rem_nxt   = rem_sh[7:0];
        dvd_nxt   = dvd_r << 1;
        dstep_nxt = dstep_r + 1'b1;
        if (dstep_r == 5'(AW - 1)) begin
          row_base   = cursor_r - 17'(rem_sh[7:0]);
          target_nxt = (ch_r == CH_LF) ? row_base + 17'(ecols) : row_base;
          state_nxt  = ST_READ;
        end
      end
      ST_SGR: begin
        if (pcount_r == '0) begin
          cur_fg_nxt = DEFAULT_COLOR; cur_bg_nxt = DEFAULT_COLOR;
        end
        if (pidx_r < pcount_r) begin
          if (pv == 14'd0) begin
            cur_fg_nxt = DEFAULT_COLOR; cur_bg_nxt = DEFAULT_COLOR;
          end else if (pv >= 14'd30 && pv <= 14'd39 && pv != 14'd38) begin
            cur_fg_nxt = 4'(pv - 14'd30);
          end else if (pv >= 14'd40 && pv <= 14'd49 && pv != 14'd48) begin
            cur_bg_nxt = 4'(pv - 14'd40);
          end
          pidx_nxt = pidx_r + 1'b1;
        end else begin
          seq_nxt = SEQ_NONE; pcount_nxt = '0; number_nxt = '0; dcount_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        // Old cell read issued at cursor; wrap target.
        if (target_r >= cells) target_nxt = 17'd0;
        state_nxt = (cursor_r < cells) ? ST_OLD : ST_NEWRD;
      end
      ST_OLD: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = {1'b0, ({1'b0, mrdata[3:0]} + 5'd10), 1'b0, mrdata[7:4],
                    mrdata[15:8], 13'(cursor_r)};
          ol_nxt = 1'b0;
          state_nxt = ST_NEWRD;
        end
      end
      ST_NEWRD: begin
        maddr = target_r[AW-1:0];
        cursor_nxt = target_r;
        state_nxt = ST_NEW;
      end
      ST_NEW: begin
        maddr = cursor_r[AW-1:0];
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = {1'b1, 5'd9, 5'd19, mrdata[15:8], 13'(cursor_r)};
          ol_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      seq_r      <= SEQ_NONE;
      cursor_r   <= '0;
      target_r   <= '0;
      cur_fg_r   <= DEFAULT_COLOR;
      cur_bg_r   <= DEFAULT_COLOR;
      pcount_r   <= '0;
      number_r   <= '0;
      dcount_r   <= '0;
      pidx_r     <= '0;
      clr_r      <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seq_r      <= seq_nxt;
      cursor_r   <= cursor_nxt;
      target_r   <= target_nxt;
      cur_fg_r   <= cur_fg_nxt;
      cur_bg_r   <= cur_bg_nxt;
      pcount_r   <= pcount_nxt;
      number_r   <= number_nxt;
      dcount_r   <= dcount_nxt;
      pidx_r     <= pidx_nxt;
      clr_r      <= clr_nxt;
      ov_r       <= ov_nxt;
    end
    od_r    <= od_nxt;
    ol_r    <= ol_nxt;
    ch_r    <= ch_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    dstep_r <= dstep_nxt;
    if (pwe) params_r[pwaddr] <= number_r;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule
`default_nettype wire
